// ===== hw/rtl/row_request_coalescing_table_assert.svh =====
// Assertion macros for the row request coalescing table.
`ifndef ROW_REQUEST_COALESCING_TABLE_ASSERT_SVH
`define ROW_REQUEST_COALESCING_TABLE_ASSERT_SVH

// Clocked check, held off while in reset.
`define RRCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define RRCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/rrct_pkg.sv =====
// Shared types, constants and helpers of the row request coalescing table.
package rrct_pkg;

  localparam int KEY_SLOTS   = 16;
  localparam int GROUP_DEPTH = 8;

  localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W   = $clog2(GROUP_DEPTH + 1);
  localparam int ENTRIES = KEY_SLOTS * GROUP_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W   = 47;
  localparam int CLK_W   = 31;
  localparam int THR_W   = 8;

  typedef struct packed {
    logic [CLK_W-1:0] clock;
    logic [THR_W-1:0] thread;
    logic             sent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_REPLY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_KEY_FULL  = 2'd1,
    ERR_GRP_FULL  = 2'd2,
    ERR_HEAD_SENT = 2'd3
  } err_e;

  localparam logic signed [31:0] NEXT_NONE = -32'sd1;

  function automatic logic [ADDR_W-1:0] ent_addr(logic [SLOT_W-1:0] slot,
                                                 logic [CNT_W-1:0] idx);
    logic [ADDR_W+CNT_W:0] a;
    a = (ADDR_W+CNT_W+1)'(slot) * (ADDR_W+CNT_W+1)'(GROUP_DEPTH)
        + (ADDR_W+CNT_W+1)'(idx);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rrct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/row_request_coalescing_table.sv =====
// Top level of the row request coalescing table.
// Input channel: in_valid_i / in_stall_o with op, table and row key, clock and
// thread. A transaction is taken while in_valid_i is high and in_stall_o low;
// in_stall_o stays high until every result of that transaction is handed over.
// Output channel: out_valid_o / out_stall_i, registered results for each
// transaction; a stalled result holds and the sequencer waits behind it.
// An add gives one result, a reply one result per released thread plus a
// summary carrying last_o.
// Sequence: the transaction is taken, then the key lookup walks the
// KEY_SLOTS slots one per cycle. An insert then shifts each entry through a
// read and a write state, a reply reads each examined entry, moves each
// compacted entry by a read and a write, and reads and rewrites the head;
// each result is then handed to the output register. All entry traffic goes
// through the single entry RAM port pair.
// Reset empties the key table; entry RAM contents are only read below the
// group count and need no clearing.
`include "row_request_coalescing_table_assert.svh"

module row_request_coalescing_table
  import rrct_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [15:0]              table_key_i,
  input  logic [30:0]              row_key_i,
  input  logic [30:0]              clock_value_i,
  input  logic [7:0]               thread_id_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic                     send_now_o,
  output logic [7:0]               released_thread_o,
  output logic signed [31:0]       next_clock_o,
  output logic [1:0]               error_o,
  output logic                     last_o
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SEARCH  = 11'b000_0000_0010,
    ST_INS_RD  = 11'b000_0000_0100,
    ST_INS_CMP = 11'b000_0000_1000,
    ST_REL_RD  = 11'b000_0001_0000,
    ST_REL_CHK = 11'b000_0010_0000,
    ST_CMP_RD  = 11'b000_0100_0000,
    ST_CMP_WR  = 11'b000_1000_0000,
    ST_HEAD_RD = 11'b001_0000_0000,
    ST_HEAD_WR = 11'b010_0000_0000,
    ST_RESP    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_SLOTS-1:0] slot_valid_q;
  logic [KEY_W-1:0]     slot_key_q [KEY_SLOTS];
  logic [CNT_W-1:0]     slot_count_q [KEY_SLOTS];

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [CLK_W-1:0]  clk_q;
  logic [THR_W-1:0]  thr_q;
  logic [SLOT_W-1:0] sc_q, sc_d, slot_q, slot_d, free_q, free_d;
  logic              free_ok_q, free_ok_d;
  logic [CNT_W-1:0]  n_q, n_d, i_q, i_d, rel_q, rel_d;

  logic [1:0]         res_kind_q, res_kind_d, res_err_q, res_err_d;
  logic               res_send_q, res_send_d, res_last_q, res_last_d;
  logic [THR_W-1:0]   res_thr_q, res_thr_d;
  logic signed [31:0] res_next_q, res_next_d;

  logic              accept, out_free, out_load;
  logic              valid_set, valid_clr, key_we, cnt_we;
  logic [SLOT_W-1:0] vk_slot;
  logic [CNT_W-1:0]  cnt_wdata;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic              hit, fr, last_slot;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign hit        = slot_valid_q[sc_q] && (slot_key_q[sc_q] == key_q);
  assign fr         = !slot_valid_q[sc_q];
  assign last_slot  = (sc_q == SLOT_W'(KEY_SLOTS - 1));

  rrct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    sc_d       = sc_q;
    slot_d     = slot_q;
    free_d     = free_q;
    free_ok_d  = free_ok_q;
    n_d        = n_q;
    i_d        = i_q;
    rel_d      = rel_q;
    res_kind_d = res_kind_q;
    res_err_d  = res_err_q;
    res_send_d = res_send_q;
    res_last_d = res_last_q;
    res_thr_d  = res_thr_q;
    res_next_d = res_next_q;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    vk_slot    = slot_q;
    cnt_wdata  = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_raddr  = '0;
    ram_wdata  = '0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sc_d      = '0;
          free_ok_d = 1'b0;
          state_d   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (fr && !free_ok_q) begin
          free_d    = sc_q;
          free_ok_d = 1'b1;
        end
        res_send_d = 1'b0;
        res_thr_d  = '0;
        res_next_d = '0;
        res_err_d  = ERR_OK;
        res_last_d = 1'b1;
        if (hit || last_slot) begin
          if (op_q == OP_ADD) begin
            res_kind_d = KIND_ADD;
            if (hit) begin
              if (slot_count_q[sc_q] >= CNT_W'(GROUP_DEPTH)) begin
                res_err_d = ERR_GRP_FULL;
                state_d   = ST_RESP;
              end else begin
                slot_d  = sc_q;
                i_d     = slot_count_q[sc_q];
                state_d = ST_INS_RD;
              end
            end else if (free_ok_q || fr) begin
              slot_d    = free_ok_q ? free_q : sc_q;
              vk_slot   = slot_d;
              valid_set = 1'b1;
              key_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = '0;
              i_d       = '0;
              state_d   = ST_INS_RD;
            end else begin
              res_err_d = ERR_KEY_FULL;
              state_d   = ST_RESP;
            end
          end else begin
            if (hit) begin
              slot_d  = sc_q;
              n_d     = slot_count_q[sc_q];
              rel_d   = '0;
              state_d = ST_REL_RD;
            end else begin
              res_kind_d = KIND_SUMMARY;
              res_next_d = NEXT_NONE;
              state_d    = ST_RESP;
            end
          end
        end else begin
          sc_d = sc_q + SLOT_W'(1);
        end
      end
      ST_INS_RD: begin
        if (i_q == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = ent_addr(slot_q, '0);
          ram_wdata  = '{clock: clk_q, thread: thr_q, sent: 1'b1};
          cnt_we     = 1'b1;
          cnt_wdata  = slot_count_q[slot_q] + CNT_W'(1);
          res_send_d = 1'b1;
          state_d    = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(slot_q, i_q - CNT_W'(1));
          state_d   = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = ent_addr(slot_q, i_q);
        if (clk_q >= ram_rdata.clock) begin
          ram_wdata = '{clock: clk_q, thread: thr_q, sent: 1'b0};
          cnt_we    = 1'b1;
          cnt_wdata = slot_count_q[slot_q] + CNT_W'(1);
          state_d   = ST_RESP;
        end else begin
          ram_wdata = ram_rdata;
          i_d       = i_q - CNT_W'(1);
          state_d   = ST_INS_RD;
        end
      end
      ST_REL_RD: begin
        if (rel_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(slot_q, rel_q);
          state_d   = ST_REL_CHK;
        end else begin
          i_d     = rel_q;
          state_d = ST_CMP_RD;
        end
      end
      ST_REL_CHK: begin
        if (ram_rdata.clock <= clk_q) begin
          res_kind_d = KIND_RELEASE;
          res_send_d = 1'b0;
          res_thr_d  = ram_rdata.thread;
          res_next_d = '0;
          res_err_d  = ERR_OK;
          res_last_d = 1'b0;
          rel_d      = rel_q + CNT_W'(1);
          state_d    = ST_RESP;
        end else begin
          i_d     = rel_q;
          state_d = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        if (rel_q != '0 && i_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(slot_q, i_q);
          state_d   = ST_CMP_WR;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = n_q - rel_q;
          if (n_q == rel_q) begin
            valid_clr  = 1'b1;
            res_kind_d = KIND_SUMMARY;
            res_send_d = 1'b0;
            res_thr_d  = '0;
            res_next_d = NEXT_NONE;
            res_err_d  = ERR_OK;
            res_last_d = 1'b1;
            state_d    = ST_RESP;
          end else begin
            state_d = ST_HEAD_RD;
          end
        end
      end
      ST_CMP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ent_addr(slot_q, i_q - rel_q);
        ram_wdata = ram_rdata;
        i_d       = i_q + CNT_W'(1);
        state_d   = ST_CMP_RD;
      end
      ST_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ent_addr(slot_q, '0);
        state_d   = ST_HEAD_WR;
      end
      ST_HEAD_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = ent_addr(slot_q, '0);
        ram_wdata  = '{clock: ram_rdata.clock, thread: ram_rdata.thread, sent: 1'b1};
        res_kind_d = KIND_SUMMARY;
        res_send_d = 1'b0;
        res_thr_d  = '0;
        res_next_d = $signed({1'b0, ram_rdata.clock});
        res_err_d  = ram_rdata.sent ? ERR_HEAD_SENT : ERR_OK;
        res_last_d = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = res_last_q ? ST_IDLE : ST_REL_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      out_valid_o  <= 1'b0;
      for (int s = 0; s < KEY_SLOTS; s++) begin
        slot_count_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (valid_set) begin
        slot_valid_q[vk_slot] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid_q[vk_slot] <= 1'b0;
      end
      if (cnt_we) begin
        slot_count_q[vk_slot] <= cnt_wdata;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      key_q <= {table_key_i, row_key_i};
      clk_q <= clock_value_i;
      thr_q <= thread_id_i;
    end
    if (key_we) begin
      slot_key_q[vk_slot] <= key_q;
    end
    if (out_load) begin
      kind_o            <= res_kind_q;
      send_now_o        <= res_send_q;
      released_thread_o <= res_thr_q;
      next_clock_o      <= res_next_q;
      error_o           <= res_err_q;
      last_o            <= res_last_q;
    end
    sc_q       <= sc_d;
    slot_q     <= slot_d;
    free_q     <= free_d;
    free_ok_q  <= free_ok_d;
    n_q        <= n_d;
    i_q        <= i_d;
    rel_q      <= rel_d;
    res_kind_q <= res_kind_d;
    res_err_q  <= res_err_d;
    res_send_q <= res_send_d;
    res_last_q <= res_last_d;
    res_thr_q  <= res_thr_d;
    res_next_q <= res_next_d;
  end

  `RRCT_ASSERT(a_busy_after_accept, accept |=> in_stall_o, "input not held off after accept")
  `RRCT_ASSERT(a_only_release_not_last,
               (out_valid_o && !last_o) |-> (kind_o == KIND_RELEASE),
               "non-final result that is not a release")
  `RRCT_ASSERT(a_count_bounded, (cnt_we |-> (cnt_wdata <= CNT_W'(GROUP_DEPTH))),
               "group count written beyond depth")
  `RRCT_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q) || !rst_ni, "state not one-hot")

endmodule
